[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent now implies consequent on the following edge
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and field widths of the COO to CSR converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    localparam int OP_W      = 2;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 16;
    localparam int VALUE_W   = 64;
    localparam int INDEX_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 9;
    localparam int S_TDATA_W = 104;
    localparam int M_USED_W  = STATUS_W + COL_W + VALUE_W + INDEX_W + INDEX_W;
    localparam int M_TDATA_W = 112;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_READ_CSR = 2'd1,
        OP_READ_RP  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_READ_OK   = 3'd0,
        STAT_CONVERTED = 3'd1,
        STAT_BAD_ROW   = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOLD,
        ST_READ,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_ROW,
        ST_CNT_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SCT_RD,
        ST_SCT_ROW,
        ST_SCT_WR,
        ST_RST_RD,
        ST_RST_WR,
        ST_DONE
    } seq_state_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic                 load;
        status_t              status;
        logic                 sel_csr;
        logic                 sel_rp;
        logic [INDEX_W-1:0]   entry_total;
    } res_t;

endpackage

`default_nettype wire

[src/ctc_sdp_ram.sv]
// ----------------------------------------------------------------------------
// ctc_sdp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/ctc_seq.sv]
// ----------------------------------------------------------------------------
// ctc_seq
// Transaction decode and conversion sequencer; drives the three RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ctc_seq #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_ROWS    = 256,
    parameter int COL_WIDTH   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // accepted transaction fields
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ctc_pkg::OP_W-1:0]               s_op,
    input  logic [ctc_pkg::ROW_W-1:0]              s_row,
    input  logic [ctc_pkg::COL_W-1:0]              s_col,
    input  logic [ctc_pkg::VALUE_W-1:0]            s_value,
    input  logic                                   s_last,
    input  logic [ctc_pkg::INDEX_W-1:0]            s_index,
    input  logic [ctc_pkg::CFG_W-1:0]              row_count,
    input  logic                                   out_free,
    output ctc_pkg::res_t                          res,
    // COO store
    output logic                                   coo_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]         coo_waddr,
    output logic [ctc_pkg::ROW_W+((COL_WIDTH < ctc_pkg::COL_W) ? COL_WIDTH
                  : ctc_pkg::COL_W)+ctc_pkg::VALUE_W-1:0] coo_wdata,
    output logic                                   coo_re,
    output logic [$clog2(MAX_ENTRIES)-1:0]         coo_raddr,
    input  logic [ctc_pkg::ROW_W+((COL_WIDTH < ctc_pkg::COL_W) ? COL_WIDTH
                  : ctc_pkg::COL_W)+ctc_pkg::VALUE_W-1:0] coo_rdata,
    // CSR store
    output logic                                   csr_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]         csr_waddr,
    output logic [((COL_WIDTH < ctc_pkg::COL_W) ? COL_WIDTH
                  : ctc_pkg::COL_W)+ctc_pkg::VALUE_W-1:0] csr_wdata,
    output logic                                   csr_re,
    output logic [$clog2(MAX_ENTRIES)-1:0]         csr_raddr,
    // row pointer store
    output logic                                   rp_we,
    output logic [$clog2(MAX_ROWS+1)-1:0]          rp_waddr,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]       rp_wdata,
    output logic                                   rp_re,
    output logic [$clog2(MAX_ROWS+1)-1:0]          rp_raddr,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]       rp_rdata
);

    import ctc_pkg::*;

    localparam int CW    = (COL_WIDTH < COL_W) ? COL_WIDTH : COL_W;
    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RAW   = $clog2(MAX_ROWS + 1);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic             converted_reg, converted_next;
    logic [CNT_W-1:0] placed_reg, placed_next;
    logic [RAW-1:0]   conv_rows_reg, conv_rows_next;
    logic [CNT_W-1:0] ent_reg, ent_next;
    logic [RAW-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0] sum_reg, sum_next;
    status_t          hold_status_reg, hold_status_next;
    logic             sel_csr_reg, sel_csr_next;

    logic [RAW-1:0]   n_use;
    logic             row_ok;
    logic [CNT_W-1:0] loaded_base;
    logic             imm_hit;
    status_t          imm_status;
    logic [ROW_W-1:0] coo_row;
    logic             coo_row_in;
    logic             last_ent;

    // row count clamped to 1..MAX_ROWS
    always_comb
    begin
        if (row_count == '0)
        begin
            n_use = RAW'(1);
        end
        else if (32'(row_count) > MAX_ROWS)
        begin
            n_use = RAW'(MAX_ROWS);
        end
        else
        begin
            n_use = RAW'(row_count);
        end
    end

    assign row_ok     = 32'(s_row) < 32'(n_use);
    assign coo_row    = coo_rdata[ROW_W-1:0];
    assign coo_row_in = 32'(coo_row) < 32'(conv_rows_reg);
    assign last_ent   = (ent_reg + CNT_W'(1)) == loaded_reg;
    assign coo_wdata  = {s_value, CW'(s_col), s_row};
    assign csr_wdata  = coo_rdata[ROW_W+CW+VALUE_W-1:ROW_W];
    assign s_ready    = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            loaded_reg      <= '0;
            converted_reg   <= 1'b0;
            placed_reg      <= '0;
            conv_rows_reg   <= RAW'(1);
            ent_reg         <= '0;
            rptr_reg        <= '0;
            sum_reg         <= '0;
            hold_status_reg <= STAT_READ_OK;
            sel_csr_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            loaded_reg      <= loaded_next;
            converted_reg   <= converted_next;
            placed_reg      <= placed_next;
            conv_rows_reg   <= conv_rows_next;
            ent_reg         <= ent_next;
            rptr_reg        <= rptr_next;
            sum_reg         <= sum_next;
            hold_status_reg <= hold_status_next;
            sel_csr_reg     <= sel_csr_next;
        end
    end

    // At most one access per RAM per step; each read-modify-write of a row pointer
    // completes before the next one is issued, so no forwarding is needed.
    always_comb
    begin
        state_next       = state_reg;
        loaded_next      = loaded_reg;
        converted_next   = converted_reg;
        placed_next      = placed_reg;
        conv_rows_next   = conv_rows_reg;
        ent_next         = ent_reg;
        rptr_next        = rptr_reg;
        sum_next         = sum_reg;
        hold_status_next = hold_status_reg;
        sel_csr_next     = sel_csr_reg;
        loaded_base      = loaded_reg;
        imm_hit          = 1'b0;
        imm_status       = STAT_READ_OK;
        res              = '0;
        coo_we           = 1'b0;
        coo_waddr        = '0;
        coo_re           = 1'b0;
        coo_raddr        = AW'(ent_reg);
        csr_we           = 1'b0;
        csr_waddr        = AW'(rp_rdata);
        csr_re           = 1'b0;
        csr_raddr        = AW'(s_index);
        rp_we            = 1'b0;
        rp_waddr         = rptr_reg;
        rp_wdata         = '0;
        rp_re            = 1'b0;
        rp_raddr         = rptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    case (op_t'(s_op))
                        OP_LOAD:
                        begin
                            // a load after conversion opens a new matrix
                            if (converted_reg)
                            begin
                                loaded_base    = '0;
                                converted_next = 1'b0;
                            end
                            loaded_next = loaded_base;
                            if (!row_ok)
                            begin
                                imm_hit    = 1'b1;
                                imm_status = STAT_BAD_ROW;
                            end
                            else if (32'(loaded_base) >= MAX_ENTRIES)
                            begin
                                imm_hit    = 1'b1;
                                imm_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                coo_we      = 1'b1;
                                coo_waddr   = AW'(loaded_base);
                                loaded_next = loaded_base + CNT_W'(1);
                                if (s_last)
                                begin
                                    conv_rows_next = n_use;
                                    rptr_next      = '0;
                                    state_next     = ST_CLR;
                                end
                            end
                        end
                        OP_READ_CSR:
                        begin
                            if (converted_reg && (32'(s_index) < 32'(placed_reg)))
                            begin
                                csr_re       = 1'b1;
                                sel_csr_next = 1'b1;
                                state_next   = ST_READ;
                            end
                            else
                            begin
                                imm_hit    = 1'b1;
                                imm_status = STAT_BAD_INDEX;
                            end
                        end
                        OP_READ_RP:
                        begin
                            if (converted_reg && (32'(s_index) <= 32'(conv_rows_reg)))
                            begin
                                rp_re        = 1'b1;
                                rp_raddr     = RAW'(s_index);
                                sel_csr_next = 1'b0;
                                state_next   = ST_READ;
                            end
                            else
                            begin
                                imm_hit    = 1'b1;
                                imm_status = STAT_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (imm_hit)
                    begin
                        if (out_free)
                        begin
                            res.load        = 1'b1;
                            res.status      = imm_status;
                            res.entry_total = INDEX_W'(loaded_next);
                        end
                        else
                        begin
                            hold_status_next = imm_status;
                            state_next       = ST_HOLD;
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    res.load        = 1'b1;
                    res.status      = hold_status_reg;
                    res.entry_total = INDEX_W'(loaded_reg);
                    state_next      = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // read data stays in the RAM output register until taken
                if (out_free)
                begin
                    res.load        = 1'b1;
                    res.status      = STAT_READ_OK;
                    res.sel_csr     = sel_csr_reg;
                    res.sel_rp      = !sel_csr_reg;
                    res.entry_total = INDEX_W'(loaded_reg);
                    state_next      = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                rp_we = 1'b1;
                if (rptr_reg == conv_rows_reg)
                begin
                    ent_next   = '0;
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    rptr_next = rptr_reg + RAW'(1);
                end
            end
            ST_CNT_RD:
            begin
                coo_re     = 1'b1;
                state_next = ST_CNT_ROW;
            end
            ST_CNT_ROW:
            begin
                if (coo_row_in)
                begin
                    rp_re      = 1'b1;
                    rp_raddr   = RAW'(coo_row);
                    state_next = ST_CNT_WR;
                end
                else if (last_ent)
                begin
                    rptr_next  = '0;
                    sum_next   = '0;
                    state_next = ST_PFX_RD;
                end
                else
                begin
                    ent_next   = ent_reg + CNT_W'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_WR:
            begin
                rp_we    = 1'b1;
                rp_waddr = RAW'(coo_row);
                rp_wdata = rp_rdata + CNT_W'(1);
                if (last_ent)
                begin
                    rptr_next  = '0;
                    sum_next   = '0;
                    state_next = ST_PFX_RD;
                end
                else
                begin
                    ent_next   = ent_reg + CNT_W'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_PFX_RD:
            begin
                if (rptr_reg == conv_rows_reg)
                begin
                    // closing pointer holds the total placed
                    rp_we       = 1'b1;
                    rp_wdata    = sum_reg;
                    placed_next = sum_reg;
                    ent_next    = '0;
                    state_next  = ST_SCT_RD;
                end
                else
                begin
                    rp_re      = 1'b1;
                    state_next = ST_PFX_WR;
                end
            end
            ST_PFX_WR:
            begin
                rp_we      = 1'b1;
                rp_wdata   = sum_reg;
                sum_next   = sum_reg + rp_rdata;
                rptr_next  = rptr_reg + RAW'(1);
                state_next = ST_PFX_RD;
            end
            ST_SCT_RD:
            begin
                coo_re     = 1'b1;
                state_next = ST_SCT_ROW;
            end
            ST_SCT_ROW:
            begin
                if (coo_row_in)
                begin
                    rp_re      = 1'b1;
                    rp_raddr   = RAW'(coo_row);
                    state_next = ST_SCT_WR;
                end
                else if (last_ent)
                begin
                    rptr_next  = '0;
                    sum_next   = '0;
                    state_next = ST_RST_RD;
                end
                else
                begin
                    ent_next   = ent_reg + CNT_W'(1);
                    state_next = ST_SCT_RD;
                end
            end
            ST_SCT_WR:
            begin
                csr_we   = 32'(rp_rdata) < MAX_ENTRIES;
                rp_we    = 1'b1;
                rp_waddr = RAW'(coo_row);
                rp_wdata = rp_rdata + CNT_W'(1);
                if (last_ent)
                begin
                    rptr_next  = '0;
                    sum_next   = '0;
                    state_next = ST_RST_RD;
                end
                else
                begin
                    ent_next   = ent_reg + CNT_W'(1);
                    state_next = ST_SCT_RD;
                end
            end
            ST_RST_RD:
            begin
                rp_re      = 1'b1;
                state_next = ST_RST_WR;
            end
            ST_RST_WR:
            begin
                // shift row ends down by one row: sum_reg carries the previous end
                rp_we    = 1'b1;
                rp_wdata = sum_reg;
                sum_next = rp_rdata;
                if (rptr_reg == conv_rows_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rptr_next  = rptr_reg + RAW'(1);
                    state_next = ST_RST_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res.load        = 1'b1;
                    res.status      = STAT_CONVERTED;
                    res.entry_total = INDEX_W'(loaded_reg);
                    converted_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_load_free, res.load |-> out_free, "result issued while output full")
    `ASSERT_CLK(a_scatter_bound, (state_reg == ST_SCT_WR) |-> (rp_rdata < placed_reg),
        "scatter slot beyond placed count")
    `ASSERT_CLK(a_conv_source, $rose(converted_reg) |-> ($past(state_reg) == ST_DONE),
        "converted set outside conversion end")
    `ASSERT_NEXT(a_conv_end, (state_reg == ST_DONE) && out_free, converted_reg && s_ready,
        "conversion end did not return to idle")

endmodule

`default_nettype wire

[src/coo_to_csr_converter.sv]
// ----------------------------------------------------------------------------
// coo_to_csr_converter
// Sparse matrix loader and COO to CSR converter with indexed read-back.
// ----------------------------------------------------------------------------
// Usage: s_axis tuser carries the op (load entry, read CSR entry, read row
//   pointer), tlast marks the final entry of a matrix, tdata the row,
//   column, 64-bit value word and read index. m_axis carries one status
//   transaction per read, per dropped load, per failed read and per finished
//   conversion; plain loads give none. cfg_we/cfg_wdata write the row count;
//   write it only while idle.
// Timing: a plain load is written to the COO store from idle; a dropped
//   load holds off the input while the output register is still full.
//   Reads: the output register of the RAM read port holds the read data
//   until the output register is free; no new transaction is taken before.
//   Conversion (last load), n rows in use: a clearing pass over the n + 1
//   row pointers, then count, prefix-sum, scatter and shift passes, built
//   on serial read-modify-write of the row pointer RAM.
// Reset: empty matrix, no conversion held, row count 1; RAMs not cleared.
//   A stalled output holds its transaction; the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_to_csr_converter #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_ROWS    = 256,
    parameter int COL_WIDTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: row[7:0], col[23:8], value[87:24], index[98:88], zero pad
    input  logic [ctc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    // tuser: op[1:0]
    input  logic [ctc_pkg::OP_W-1:0]         s_axis_tuser,
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: status[2:0], col_out[18:3], value_out[82:19],
    //        row_pointer[93:83], entry_total[104:94], zero pad
    output logic [ctc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // row count register
    input  logic                             cfg_we,
    input  logic [ctc_pkg::CFG_W-1:0]        cfg_wdata
);

    import ctc_pkg::*;

    localparam int CW     = (COL_WIDTH < COL_W) ? COL_WIDTH : COL_W;
    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RAW    = $clog2(MAX_ROWS + 1);
    localparam int COO_W  = ROW_W + CW + VALUE_W;
    localparam int CSR_W  = CW + VALUE_W;
    localparam int COL_LSB   = ROW_W;
    localparam int VAL_LSB   = COL_LSB + COL_W;
    localparam int IDX_LSB   = VAL_LSB + VALUE_W;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    logic [CFG_W-1:0]     row_count_reg, row_count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 out_free;
    res_t                 res;

    logic                 coo_we, coo_re;
    logic [AW-1:0]        coo_waddr, coo_raddr;
    logic [COO_W-1:0]     coo_wdata, coo_rdata;
    logic                 csr_we, csr_re;
    logic [AW-1:0]        csr_waddr, csr_raddr;
    logic [CSR_W-1:0]     csr_wdata, csr_rdata;
    logic                 rp_we, rp_re;
    logic [RAW-1:0]       rp_waddr, rp_raddr;
    logic [CNT_W-1:0]     rp_wdata, rp_rdata;

    logic [COL_W-1:0]     col_field;
    logic [VALUE_W-1:0]   value_field;
    logic [INDEX_W-1:0]   rp_field;

    assign out_free = !m_tvalid_reg || m_axis_tready;

    ctc_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_ROWS    (MAX_ROWS),
        .COL_WIDTH   (COL_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_op      (s_axis_tuser),
        .s_row     (s_axis_tdata[ROW_W-1:0]),
        .s_col     (s_axis_tdata[VAL_LSB-1:COL_LSB]),
        .s_value   (s_axis_tdata[IDX_LSB-1:VAL_LSB]),
        .s_last    (s_axis_tlast),
        .s_index   (s_axis_tdata[IDX_LSB+INDEX_W-1:IDX_LSB]),
        .row_count (row_count_reg),
        .out_free  (out_free),
        .res       (res),
        .coo_we    (coo_we),
        .coo_waddr (coo_waddr),
        .coo_wdata (coo_wdata),
        .coo_re    (coo_re),
        .coo_raddr (coo_raddr),
        .coo_rdata (coo_rdata),
        .csr_we    (csr_we),
        .csr_waddr (csr_waddr),
        .csr_wdata (csr_wdata),
        .csr_re    (csr_re),
        .csr_raddr (csr_raddr),
        .rp_we     (rp_we),
        .rp_waddr  (rp_waddr),
        .rp_wdata  (rp_wdata),
        .rp_re     (rp_re),
        .rp_raddr  (rp_raddr),
        .rp_rdata  (rp_rdata)
    );

    // loaded entries: {value, col, row}
    ctc_sdp_ram #(
        .WIDTH (COO_W),
        .DEPTH (MAX_ENTRIES)
    ) u_coo_ram (
        .clk   (clk),
        .we    (coo_we),
        .waddr (coo_waddr),
        .wdata (coo_wdata),
        .re    (coo_re),
        .raddr (coo_raddr),
        .rdata (coo_rdata)
    );

    // entries in CSR order: {value, col}
    ctc_sdp_ram #(
        .WIDTH (CSR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_csr_ram (
        .clk   (clk),
        .we    (csr_we),
        .waddr (csr_waddr),
        .wdata (csr_wdata),
        .re    (csr_re),
        .raddr (csr_raddr),
        .rdata (csr_rdata)
    );

    // per-row counts, then row starts
    ctc_sdp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ROWS + 1)
    ) u_rp_ram (
        .clk   (clk),
        .we    (rp_we),
        .waddr (rp_waddr),
        .wdata (rp_wdata),
        .re    (rp_re),
        .raddr (rp_raddr),
        .rdata (rp_rdata)
    );

    // fields not belonging to the read kind go out as zero
    assign col_field   = res.sel_csr ? COL_W'(csr_rdata[CW-1:0]) : '0;
    assign value_field = res.sel_csr ? csr_rdata[CSR_W-1:CW] : '0;
    assign rp_field    = res.sel_rp ? INDEX_W'(rp_rdata) : '0;

    always_comb
    begin
        row_count_next = row_count_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        if (cfg_we)
        begin
            row_count_next = cfg_wdata;
        end
        if (res.load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, res.entry_total, rp_field,
                             value_field, col_field, res.status};
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_W'(1);
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
